@@ design/assert_macros.svh @@
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define HSVCC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hsvcc assertion failed");

// Concurrent assertion that is also checked while reset is held.
`define HSVCC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("hsvcc assertion failed");

`endif

@@ design/hsvcc_pkg.sv @@
// Package with the types, constants and window test of the HSV color classifier.
package hsvcc_pkg;

    // Field widths.
    localparam int CH_W      = 8;
    localparam int HUE_W     = 12;
    localparam int CLS_W     = 3;
    localparam int WIN_W     = 56;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_WIN   = 5;

    // Hue dividend and saturation dividend widths.
    localparam int NUM_W  = 20;
    localparam int SNUM_W = 16;
    localparam int SNW    = 22;

    // Division pipeline: quotient bits retired per stage and stage count.
    localparam int BITS_PER_STG = 2;
    localparam int DIV_STAGES   = HUE_W / BITS_PER_STG;

    // Hue scale in eighths of a degree.
    localparam int HUE_60  = 480;
    localparam int HUE_120 = 960;
    localparam int HUE_240 = 1920;
    localparam int HUE_360 = 2880;

    // Class codes.
    localparam logic [CLS_W-1:0] CLS_RED    = 3'd0;
    localparam logic [CLS_W-1:0] CLS_GREEN  = 3'd1;
    localparam logic [CLS_W-1:0] CLS_BLUE   = 3'd2;
    localparam logic [CLS_W-1:0] CLS_YELLOW = 3'd3;
    localparam logic [CLS_W-1:0] CLS_ORANGE = 3'd4;
    localparam logic [CLS_W-1:0] CLS_NONE   = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RED_WIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_WIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_WIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_WIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORANGE_WIN = 3'd4;

    // Max-channel sector codes.
    localparam logic [1:0] SEC_R = 2'd0;
    localparam logic [1:0] SEC_G = 2'd1;
    localparam logic [1:0] SEC_B = 2'd2;

    typedef logic [WIN_W-1:0] t_win;

    // Window reset values, in test order.
    localparam t_win WIN_RESET [NUM_WIN] = '{
        56'd53791403507255992,
        56'd50455484797583848,
        56'd50435695738193232,
        56'd71917953915683024,
        56'd71945441705230424
    };

    // Class reported by each window, in test order.
    localparam logic [CLS_W-1:0] WIN_CLASS [NUM_WIN] = '{
        CLS_RED, CLS_GREEN, CLS_BLUE, CLS_YELLOW, CLS_ORANGE
    };

    // Pixel as taken from the input channel.
    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } t_px;

    // Max/min stage result.
    typedef struct packed {
        logic [CH_W-1:0]        mx;
        logic [CH_W-1:0]        delta;
        logic [1:0]             sec;
        logic signed [CH_W:0]   diff;
    } t_s1;

    // One stage of the two restoring dividers running side by side.
    typedef struct packed {
        logic [NUM_W-1:0]  hrem;
        logic [HUE_W-1:0]  hq;
        logic [SNUM_W-1:0] srem;
        logic [CH_W-1:0]   sq;
        logic [CH_W-1:0]   delta;
        logic [CH_W-1:0]   mx;
    } t_div;

    // Strict window test; a hue window with low above high wraps through zero.
    function automatic logic win_hit(input t_win w, input logic [HUE_W-1:0] h,
                                     input logic [CH_W-1:0] s, input logic [CH_W-1:0] v);
        logic [HUE_W-1:0] h_lo;
        logic [HUE_W-1:0] h_hi;
        logic [CH_W-1:0]  s_lo;
        logic [CH_W-1:0]  s_hi;
        logic [CH_W-1:0]  v_lo;
        logic [CH_W-1:0]  v_hi;
        logic             hue_ok;
        h_lo = w[11:0];
        h_hi = w[23:12];
        s_lo = w[31:24];
        s_hi = w[39:32];
        v_lo = w[47:40];
        v_hi = w[55:48];
        if (h_lo > h_hi) begin
            hue_ok = (h > h_lo) || (h < h_hi);
        end else begin
            hue_ok = (h > h_lo) && (h < h_hi);
        end
        return hue_ok && (s > s_lo) && (s < s_hi) && (v > v_lo) && (v < v_hi);
    endfunction

endpackage

@@ design/hsvcc_pix_if.sv @@
// Input channel interface carrying one RGB pixel per transaction.
interface hsvcc_pix_if;
    logic                       valid;
    logic                       ready;
    logic [hsvcc_pkg::CH_W-1:0] red_in;
    logic [hsvcc_pkg::CH_W-1:0] green_in;
    logic [hsvcc_pkg::CH_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

@@ design/hsvcc_cls_if.sv @@
// Output channel interface carrying one classification result per transaction.
interface hsvcc_cls_if;
    logic                        valid;
    logic                        ready;
    logic [hsvcc_pkg::CLS_W-1:0] color_class;
    logic [hsvcc_pkg::HUE_W-1:0] hue;
    logic [hsvcc_pkg::CH_W-1:0]  saturation;
    logic [hsvcc_pkg::CH_W-1:0]  brightness;
    logic                        hue_defined;

    modport source (output valid, output color_class, output hue, output saturation,
                    output brightness, output hue_defined, input ready);
    modport sink (input valid, input color_class, input hue, input saturation,
                  input brightness, input hue_defined, output ready);
endinterface

@@ design/hsv_range_color_classifier.sv @@
// Top level of the RGB to HSV converter and window color classifier.
//
//  Channel   Direction  Carries
//  i_pix     in         red_in, green_in, blue_in (8 bits each)
//  o_cls     out        color_class, hue, saturation, brightness, hue_defined
//  i_cfg_*   in         window register writes (index 0..4, 56-bit data)
//
// One pixel per clock when the output is taken; a result passes through ten register
// stages from acceptance to being shown, six of them the radix-4 division steps that
// produce hue and saturation.
// Reset restores the five windows to their defaults and empties the pipeline.
// Every stage has its own valid bit and moves when the stage after it is empty
// or moving, so a stall on the output fills bubbles before it stops the input.
module hsv_range_color_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hsvcc_pix_if.sink                       i_pix,
    hsvcc_cls_if.source                     o_cls,
    input  logic                            i_cfg_we,
    input  logic [hsvcc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hsvcc_pkg::WIN_W-1:0]     i_cfg_data
);
    import hsvcc_pkg::*;

    // Stage positions in the valid vector.
    localparam int STG_S0   = 0;
    localparam int STG_S1   = 1;
    localparam int STG_DIV0 = 2;
    localparam int NSTG     = DIV_STAGES + 4;
    localparam int STG_OUT  = NSTG - 1;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    t_win r_win [NUM_WIN];

    t_px  r_s0;
    t_s1  r_s1;
    t_s1  n_s1;
    t_div r_div [DIV_STAGES+1];
    t_div n_div0;
    t_div n_div [1:DIV_STAGES];

    logic [CLS_W-1:0] r_cls;
    logic [HUE_W-1:0] r_hue;
    logic [CH_W-1:0]  r_sat;
    logic [CH_W-1:0]  r_bri;
    logic             r_def;
    logic [CLS_W-1:0] n_cls;
    logic [HUE_W-1:0] n_hue;
    logic [CH_W-1:0]  n_sat;
    logic             n_def;

    // Stage advance: a stage loads when it is empty or its contents move on.
    always_comb begin
        en[STG_OUT] = !r_vld[STG_OUT] || o_cls.ready;
        for (int k = STG_OUT - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_pix.ready = en[STG_S0];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[STG_S0]) begin
                r_vld[STG_S0] <= i_pix.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Window registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WIN; i++) begin
                r_win[i] <= WIN_RESET[i];
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RED_WIN:    r_win[0] <= i_cfg_data;
                CFG_GREEN_WIN:  r_win[1] <= i_cfg_data;
                CFG_BLUE_WIN:   r_win[2] <= i_cfg_data;
                CFG_YELLOW_WIN: r_win[3] <= i_cfg_data;
                CFG_ORANGE_WIN: r_win[4] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Max, min and hue sector of the pixel.
    always_comb begin
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] mn;
        mx = r_s0.r;
        if (r_s0.g > mx) mx = r_s0.g;
        if (r_s0.b > mx) mx = r_s0.b;
        mn = r_s0.r;
        if (r_s0.g < mn) mn = r_s0.g;
        if (r_s0.b < mn) mn = r_s0.b;
        n_s1.mx    = mx;
        n_s1.delta = mx - mn;
        if (r_s0.r == mx) begin
            n_s1.sec  = SEC_R;
            n_s1.diff = $signed({1'b0, r_s0.g}) - $signed({1'b0, r_s0.b});
        end else if (r_s0.g == mx) begin
            n_s1.sec  = SEC_G;
            n_s1.diff = $signed({1'b0, r_s0.b}) - $signed({1'b0, r_s0.r});
        end else begin
            n_s1.sec  = SEC_B;
            n_s1.diff = $signed({1'b0, r_s0.r}) - $signed({1'b0, r_s0.g});
        end
    end

    // Dividends: hue numerator with the red sector wrapped, and 255 times delta.
    always_comb begin
        logic signed [SNW-1:0] dl;
        logic signed [SNW-1:0] df;
        logic signed [SNW-1:0] base;
        logic signed [SNW-1:0] num;
        dl = $signed({{(SNW-CH_W){1'b0}}, r_s1.delta});
        df = SNW'(r_s1.diff);
        unique case (r_s1.sec)
            SEC_R:   base = '0;
            SEC_G:   base = SNW'(HUE_120 * dl);
            SEC_B:   base = SNW'(HUE_240 * dl);
            default: base = '0;
        endcase
        num = base + SNW'(HUE_60 * df);
        if (num < 0) begin
            num = num + SNW'(HUE_360 * dl);
        end
        n_div0.hrem  = NUM_W'(num);
        n_div0.hq    = '0;
        n_div0.srem  = {r_s1.delta, {CH_W{1'b0}}} - SNUM_W'(r_s1.delta);
        n_div0.sq    = '0;
        n_div0.delta = r_s1.delta;
        n_div0.mx    = r_s1.mx;
    end

    // Restoring division, two quotient bits per stage for both dividers.
    // The saturation quotient only has its low eight bits, so it joins late.
    always_comb begin
        t_div             w;
        logic [3:0]       p;
        logic [NUM_W-1:0] hsub;
        logic [SNUM_W-1:0] ssub;
        for (int k = 0; k < DIV_STAGES; k++) begin
            w = r_div[k];
            for (int j = 0; j < BITS_PER_STG; j++) begin
                p    = 4'(HUE_W - 1 - BITS_PER_STG * k - j);
                hsub = NUM_W'(w.delta) << p;
                if (w.hrem >= hsub) begin
                    w.hrem  = w.hrem - hsub;
                    w.hq[p] = 1'b1;
                end
                if (p < 4'(CH_W)) begin
                    ssub = SNUM_W'(w.mx) << p;
                    if (w.srem >= ssub) begin
                        w.srem       = w.srem - ssub;
                        w.sq[p[2:0]] = 1'b1;
                    end
                end
            end
            n_div[k+1] = w;
        end
    end

    // Final hue and saturation, then the first matching window.
    always_comb begin
        t_div d;
        d     = r_div[DIV_STAGES];
        n_def = (d.delta != '0);
        n_hue = n_def ? d.hq : '0;
        n_sat = (d.mx != '0) ? d.sq : '0;
        n_cls = CLS_NONE;
        for (int i = NUM_WIN - 1; i >= 0; i--) begin
            if (n_def && win_hit(r_win[i], n_hue, n_sat, d.mx)) begin
                n_cls = WIN_CLASS[i];
            end
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (en[STG_S0]) begin
            r_s0 <= '{r: i_pix.red_in, g: i_pix.green_in, b: i_pix.blue_in};
        end
        if (en[STG_S1]) begin
            r_s1 <= n_s1;
        end
        if (en[STG_DIV0]) begin
            r_div[0] <= n_div0;
        end
        for (int k = 1; k <= DIV_STAGES; k++) begin
            if (en[STG_DIV0+k]) begin
                r_div[k] <= n_div[k];
            end
        end
        if (en[STG_OUT]) begin
            r_cls <= n_cls;
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_bri <= r_div[DIV_STAGES].mx;
            r_def <= n_def;
        end
    end

    // Output channel.
    assign o_cls.valid       = r_vld[STG_OUT];
    assign o_cls.color_class = r_cls;
    assign o_cls.hue         = r_hue;
    assign o_cls.saturation  = r_sat;
    assign o_cls.brightness  = r_bri;
    assign o_cls.hue_defined = r_def;

endmodule

@@ design/hsvcc_checker.sv @@
// Port-level checker for the HSV color classifier and its bind statement.
`include "assert_macros.svh"

module hsvcc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [hsvcc_pkg::CLS_W-1:0] i_color_class,
    input logic [hsvcc_pkg::HUE_W-1:0] i_hue,
    input logic [hsvcc_pkg::CH_W-1:0]  i_saturation,
    input logic [hsvcc_pkg::CH_W-1:0]  i_brightness,
    input logic                        i_hue_defined
);
    import hsvcc_pkg::*;

    logic [CLS_W+HUE_W+2*CH_W:0] out_payload;
    logic                        out_stall;
    logic                        sat_nz;
    logic                        grey_out;
    logic                        grey_ok;
    logic                        def_out;
    logic                        hue_ok;

    // Terms shared by the properties below.
    assign out_payload = {i_color_class, i_hue, i_saturation, i_brightness, i_hue_defined};
    assign out_stall   = i_out_valid && !i_out_ready;
    assign sat_nz      = (i_saturation != '0);
    assign grey_out    = i_out_valid && !i_hue_defined;
    assign grey_ok     = (i_color_class == CLS_NONE) && (i_hue == '0);
    assign def_out     = i_out_valid && i_hue_defined;
    assign hue_ok      = (i_hue < HUE_W'(HUE_360)) && (i_brightness != '0);

    // Reset empties the pipeline, so no result shows right after it.
    `HSVCC_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !i_out_valid)

    // A stalled result stays and keeps its payload.
    `HSVCC_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> i_out_valid && $stable(out_payload))

    // A defined hue means a nonzero spread, which always gives nonzero saturation.
    `HSVCC_ASSERT(a_sat_def, i_clk, i_rst_n, i_out_valid |-> (i_hue_defined == sat_nz))

    // Grey and black pixels are never classified and report hue zero.
    `HSVCC_ASSERT(a_grey_none, i_clk, i_rst_n, grey_out |-> grey_ok)

    // A defined hue lies below a full turn and comes with a nonzero value.
    `HSVCC_ASSERT(a_hue_range, i_clk, i_rst_n, def_out |-> hue_ok)

endmodule

bind hsv_range_color_classifier hsvcc_checker u_hsvcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_cls.valid),
    .i_out_ready   (o_cls.ready),
    .i_color_class (o_cls.color_class),
    .i_hue         (o_cls.hue),
    .i_saturation  (o_cls.saturation),
    .i_brightness  (o_cls.brightness),
    .i_hue_defined (o_cls.hue_defined)
);

@@ test/hsvcc_checker.sv @@
// Checker that predicts each HSV classification result and compares it with the block output.
module hsvcc_scoreboard (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hsvcc_pix_if                            i_pix,
    hsvcc_cls_if                            i_cls,
    input  logic                            i_cfg_we,
    input  logic [hsvcc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hsvcc_pkg::WIN_W-1:0]     i_cfg_data,
    output int                              o_err_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import hsvcc_pkg::*;

    localparam int REPORT_LIMIT = 10;
    localparam int SAT_FULL     = 255;

    // Pixel together with the classification it should produce.
    typedef struct packed {
        logic [CH_W-1:0]  r;
        logic [CH_W-1:0]  g;
        logic [CH_W-1:0]  b;
        logic [CLS_W-1:0] color_class;
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
        logic             hue_defined;
    } t_hsv_class;

    t_win       window_copy [NUM_WIN];
    t_hsv_class classified_q [$];

    // Strict bounds on every field; hue wraps through zero when low is above high.
    function automatic bit in_window(input t_win w, input int h, input int s, input int v);
        int h_lo;
        int h_hi;
        bit hue_ok;
        h_lo = int'(w[11:0]);
        h_hi = int'(w[23:12]);
        if (h_lo > h_hi) begin
            hue_ok = (h > h_lo) || (h < h_hi);
        end else begin
            hue_ok = (h > h_lo) && (h < h_hi);
        end
        return hue_ok && (s > int'(w[31:24])) && (s < int'(w[39:32]))
               && (v > int'(w[47:40])) && (v < int'(w[55:48]));
    endfunction

    // Convert the pixel to HSV and pick the first window that holds it.
    function automatic t_hsv_class classify_pixel(input logic [CH_W-1:0] r,
                                                  input logic [CH_W-1:0] g,
                                                  input logic [CH_W-1:0] b);
        int         red;
        int         grn;
        int         blu;
        int         mx;
        int         mn;
        int         delta;
        int         num;
        t_hsv_class res;
        red = int'(r);
        grn = int'(g);
        blu = int'(b);
        mx = red;
        if (grn > mx) mx = grn;
        if (blu > mx) mx = blu;
        mn = red;
        if (grn < mn) mn = grn;
        if (blu < mn) mn = blu;
        delta = mx - mn;

        res.r           = r;
        res.g           = g;
        res.b           = b;
        res.color_class = CLS_NONE;
        res.hue         = '0;
        res.hue_defined = 1'b0;
        res.brightness  = CH_W'(mx);
        res.saturation  = (mx != 0) ? CH_W'((SAT_FULL * delta) / mx) : '0;

        if (delta != 0) begin
            // Ties on the largest channel favor red, then green.
            if (red == mx) begin
                num = HUE_60 * (grn - blu);
            end else if (grn == mx) begin
                num = HUE_120 * delta + HUE_60 * (blu - red);
            end else begin
                num = HUE_240 * delta + HUE_60 * (red - grn);
            end
            if (num < 0) num += HUE_360 * delta;
            res.hue         = HUE_W'(num / delta);
            res.hue_defined = 1'b1;
            // Walk backward so that the earliest matching window wins.
            for (int i = NUM_WIN - 1; i >= 0; i--) begin
                if (in_window(window_copy[i], int'(res.hue), int'(res.saturation), mx)) begin
                    res.color_class = WIN_CLASS[i];
                end
            end
        end
        return res;
    endfunction

    // Track window writes, predict each accepted pixel and check each result transaction.
    always @(posedge i_clk) begin
        t_hsv_class want;
        if (!i_rst_n) begin
            foreach (window_copy[i]) window_copy[i] = WIN_RESET[i];
            classified_q.delete();
        end else begin
            if (i_cfg_we && (i_cfg_idx < NUM_WIN)) begin
                window_copy[i_cfg_idx] = i_cfg_data;
            end
            if (i_pix.valid && i_pix.ready) begin
                classified_q.insert(classified_q.size(),
                                    classify_pixel(i_pix.red_in, i_pix.green_in,
                                                   i_pix.blue_in));
            end
            if (i_cls.valid && i_cls.ready) begin
                if (classified_q.size() == 0) begin
                    o_err_count++;
                    if (o_err_count <= REPORT_LIMIT) begin
                        $display("%0t: result with nothing expected: class %0d hue %0d",
                                 $realtime, i_cls.color_class, i_cls.hue);
                    end
                end else begin
                    want = classified_q.pop_front();
                    if (want.color_class !== i_cls.color_class || want.hue !== i_cls.hue
                        || want.saturation !== i_cls.saturation
                        || want.brightness !== i_cls.brightness
                        || want.hue_defined !== i_cls.hue_defined) begin
                        o_err_count++;
                        if (o_err_count <= REPORT_LIMIT) begin
                            $display("%0t: mismatch for rgb %0d %0d %0d", $realtime,
                                     want.r, want.g, want.b);
                            $display("  expected class %0d hue %0d sat %0d val %0d def %0b",
                                     want.color_class, want.hue, want.saturation,
                                     want.brightness, want.hue_defined);
                            $display("  actual   class %0d hue %0d sat %0d val %0d def %0b",
                                     i_cls.color_class, i_cls.hue, i_cls.saturation,
                                     i_cls.brightness, i_cls.hue_defined);
                        end
                    end
                end
            end
        end
        o_pending = classified_q.size();
    end

endmodule

@@ test/tb_hsv_range_color_classifier.sv @@
// Testbench top that drives pixels and window settings into the HSV color classifier.
module tb_hsv_range_color_classifier;
    timeunit 1ns;
    timeprecision 1ps;
    import hsvcc_pkg::*;

    localparam int RESET_CYCLES     = 9;
    localparam int LATENCY_CYCLES   = 16;
    localparam int LONG_HOLD_CYCLES = 40;
    localparam int CYCLE_LIMIT      = 300000;

    // Register index of each window, in test order, and the first index with no register.
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_IDX [NUM_WIN] = '{
        CFG_RED_WIN, CFG_GREEN_WIN, CFG_BLUE_WIN, CFG_YELLOW_WIN, CFG_ORANGE_WIN
    };
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = CFG_ORANGE_WIN + 3'd1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [WIN_W-1:0]     cfg_data;
    int                   err_count;
    int                   pending;
    int                   cycle_count = 0;
    bit                   tx_idle_en  = 1'b1;
    bit                   rx_idle_en  = 1'b1;
    bit                   hold_req    = 1'b0;
    t_win                 win_set [NUM_WIN];

    hsvcc_pix_if pix_ch ();
    hsvcc_cls_if cls_ch ();

    hsv_range_color_classifier uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_ch),
        .o_cls      (cls_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    hsvcc_scoreboard u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_ch),
        .i_cls       (cls_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // 2 ns clock.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        cls_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                cls_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                cls_ch.ready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                cls_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                cls_ch.ready <= 1'b1;
            end else begin
                cls_ch.ready <= 1'b1;
            end
        end
    end

    function automatic t_win pack_window(input logic [HUE_W-1:0] h_lo,
                                         input logic [HUE_W-1:0] h_hi,
                                         input logic [CH_W-1:0] s_lo, input logic [CH_W-1:0] s_hi,
                                         input logic [CH_W-1:0] v_lo, input logic [CH_W-1:0] v_hi);
        return {v_hi, v_lo, s_hi, s_lo, h_hi, h_lo};
    endfunction

    // Mostly plausible windows, some of them wrapping, and now and then raw random bits.
    function automatic t_win make_window();
        int h_lo;
        int s_lo;
        int v_lo;
        if ($urandom_range(0, 5) == 0) begin
            return WIN_W'({$urandom, $urandom});
        end
        h_lo = $urandom_range(0, HUE_360 - 1);
        s_lo = $urandom_range(0, 120);
        v_lo = $urandom_range(0, 120);
        return pack_window(HUE_W'(h_lo), HUE_W'((h_lo + $urandom_range(1, 1200)) % HUE_360),
                           CH_W'(s_lo), CH_W'($urandom_range(s_lo + 1, 255)),
                           CH_W'(v_lo), CH_W'($urandom_range(v_lo + 1, 255)));
    endfunction

    function automatic logic [CH_W-1:0] corner_channel();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // Write all five windows, then one unused index that must change nothing.
    task automatic load_windows(input t_win wins [NUM_WIN]);
        foreach (wins[i]) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_WIN_IDX[i];
            cfg_data <= wins[i];
            @(posedge i_clk);
        end
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_IDX_W'($urandom_range(CFG_IDX_UNUSED, (1 << CFG_IDX_W) - 1));
        cfg_data <= WIN_W'({$urandom, $urandom});
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one pixel, after an optional idle burst with junk on the bus, until it is taken.
    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            pix_ch.valid    <= 1'b0;
            pix_ch.red_in   <= CH_W'($urandom);
            pix_ch.green_in <= CH_W'($urandom);
            pix_ch.blue_in  <= CH_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.red_in   <= r;
        pix_ch.green_in <= g;
        pix_ch.blue_in  <= b;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
    endtask

    // Mix of uniform pixels, greys, ties on the largest channel and corner values.
    task automatic send_random_pixel();
        logic [CH_W-1:0] hi;
        logic [CH_W-1:0] lo;
        case ($urandom_range(0, 9))
            0: begin
                hi = CH_W'($urandom);
                send_pixel(hi, hi, hi);
            end
            1: begin
                hi = CH_W'($urandom_range(1, 255));
                lo = CH_W'($urandom_range(0, hi - 1));
                case ($urandom_range(0, 2))
                    0: send_pixel(hi, hi, lo);
                    1: send_pixel(hi, lo, hi);
                    default: send_pixel(lo, hi, hi);
                endcase
            end
            2: send_pixel(corner_channel(), corner_channel(), corner_channel());
            default: send_pixel(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
        endcase
    endtask

    task automatic send_random_pixels(input int count, input int hold_at);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) hold_req = 1'b1;
            send_random_pixel();
        end
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY_CYCLES) @(posedge i_clk);
    endtask

    // Main sequence of window settings and pixel streams.
    initial begin
        i_rst_n         = 1'b0;
        pix_ch.valid    = 1'b0;
        pix_ch.red_in   = '0;
        pix_ch.green_in = '0;
        pix_ch.blue_in  = '0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels on the reset windows: greys, primaries, hue wrap, ties, tiny values.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd128, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd10);
        send_pixel(8'd200, 8'd200, 8'd50);
        send_pixel(8'd50, 8'd200, 8'd200);
        send_pixel(8'd200, 8'd50, 8'd200);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd180, 8'd60, 8'd60);
        send_pixel(8'd60, 8'd160, 8'd60);
        send_pixel(8'd50, 8'd60, 8'd180);
        send_pixel(8'd180, 8'd170, 8'd40);
        send_pixel(8'd200, 8'd110, 8'd30);

        // Random pixels on the reset windows, with one long stall on the result side.
        send_random_pixels(400, 150);
        wait_idle();

        // Every window closed: all bounds zero, so equal hue bounds never match.
        foreach (win_set[i]) win_set[i] = '0;
        load_windows(win_set);
        send_random_pixels(60, -1);
        wait_idle();

        // Every bit set: hue bounds equal again, nothing matches.
        foreach (win_set[i]) win_set[i] = '1;
        load_windows(win_set);
        send_random_pixels(60, -1);
        wait_idle();

        // Widest windows, green with a wrap that covers almost the whole hue field.
        foreach (win_set[i]) begin
            win_set[i] = pack_window(12'h000, 12'hFFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
        end
        win_set[0] = '0;
        win_set[1] = pack_window(12'hFFF, 12'hFFE, 8'h00, 8'hFF, 8'h00, 8'hFF);
        load_windows(win_set);
        send_random_pixels(60, -1);
        wait_idle();

        // Random window settings.
        repeat (4) begin
            foreach (win_set[i]) win_set[i] = make_window();
            load_windows(win_set);
            send_random_pixels(250, -1);
            wait_idle();
        end

        // Back to the reset windows with both sides streaming at full rate.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        load_windows(WIN_RESET);
        send_random_pixels(200, -1);
        wait_idle();

        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ hsv_range_color_classifier.f @@
+incdir+design
design/hsvcc_pkg.sv
design/hsvcc_pix_if.sv
design/hsvcc_cls_if.sv
design/hsv_range_color_classifier.sv
design/hsvcc_checker.sv
test/hsvcc_checker.sv
test/tb_hsv_range_color_classifier.sv
